// ===== design/mpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types, constants and the cos/sin table of the momentum projection
// accumulator.
// ----------------------------------------------------------------------------
package mpa_pkg;

  // lattice extents and phase resolution, as powers of two
  localparam int unsigned LAT_X_LOG2   = 5;
  localparam int unsigned LAT_Y_LOG2   = 5;
  localparam int unsigned LAT_Z_LOG2   = 5;
  localparam int unsigned PHASE_LOG2   = 6;
  localparam int unsigned PHASE_STEPS  = 1 << PHASE_LOG2;
  localparam int unsigned QUARTER      = PHASE_STEPS / 4;
  localparam int unsigned QUARTER_LOG2 = PHASE_LOG2 - 2;
  localparam int unsigned DEN_LOG2     = LAT_X_LOG2 + LAT_Y_LOG2 + LAT_Z_LOG2;

  localparam int unsigned COORD_W = 6;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned TRIG_W  = 17;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_SOURCE_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_Z   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MOMENTUM_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MOMENTUM_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MOMENTUM_Z = 3'd5;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam longint CORDIC_X0 = 64'sd652032874;
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0]  cos_v;
    logic signed [TRIG_W-1:0]  sin_v;
    logic signed [VALUE_W-1:0] value_re;
    logic signed [VALUE_W-1:0] value_im;
    logic                      last_site;
  } mpa_item_t;

  typedef logic [QUARTER-1:0][31:0] trig_rom_t;

  function automatic logic [15:0] to_q15(input longint v);
    longint t;
    t = (v + 64'sd16384) >>> 15;
    if (t > 64'sd32767) t = 64'sd32767;
    if (t < -64'sd32768) t = -64'sd32768;
    return t[15:0];
  endfunction

  // first-quadrant cos/sin, computed at elaboration by the rotation CORDIC
  function automatic trig_rom_t trig_rom_build();
    trig_rom_t rom;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    for (int j = 0; j < QUARTER; j++) begin
      x = CORDIC_X0;
      y = 0;
      z = longint'(j) <<< (32 - PHASE_LOG2);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_TURNS[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_TURNS[i];
        end
      end
      rom[j] = {to_q15(x), to_q15(y)};
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = trig_rom_build();

endpackage
`default_nettype wire

// ===== design/mpa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_front
// Holds the source/momentum registers, forms the phase index of each site
// and looks up the rotated cos/sin pair for the queue.
// ----------------------------------------------------------------------------
module mpa_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [mpa_pkg::IDX_W-1:0]            cfg_index_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]          cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [mpa_pkg::COORD_W-1:0]          site_x_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]          site_y_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]          site_z_i,
  input  wire logic signed [mpa_pkg::VALUE_W-1:0]   value_re_i,
  input  wire logic signed [mpa_pkg::VALUE_W-1:0]   value_im_i,
  input  wire logic                                 last_site_i,
  output logic                                      q_valid_o,
  input  wire logic                                 q_ready_i,
  output mpa_pkg::mpa_item_t                        q_item_o
);

  localparam int unsigned DW   = mpa_pkg::DEN_LOG2;
  localparam int unsigned PSL  = mpa_pkg::PHASE_LOG2;
  localparam int unsigned KW   = DW + PSL + 2;
  localparam int unsigned CW   = mpa_pkg::COORD_W;
  localparam int unsigned PW   = 2 * CW + 1;
  localparam int unsigned SHX  = mpa_pkg::LAT_Y_LOG2 + mpa_pkg::LAT_Z_LOG2;
  localparam int unsigned SHY  = mpa_pkg::LAT_X_LOG2 + mpa_pkg::LAT_Z_LOG2;
  localparam int unsigned SHZ  = mpa_pkg::LAT_X_LOG2 + mpa_pkg::LAT_Y_LOG2;
  localparam int unsigned TW   = mpa_pkg::TRIG_W;

  logic [CW-1:0] src_x_q, src_y_q, src_z_q;
  logic [CW-1:0] mom_x_q, mom_y_q, mom_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q <= '0;
      src_y_q <= '0;
      src_z_q <= '0;
      mom_x_q <= '0;
      mom_y_q <= '0;
      mom_z_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mpa_pkg::REG_SOURCE_X:   src_x_q <= cfg_data_i;
        mpa_pkg::REG_SOURCE_Y:   src_y_q <= cfg_data_i;
        mpa_pkg::REG_SOURCE_Z:   src_z_q <= cfg_data_i;
        mpa_pkg::REG_MOMENTUM_X: mom_x_q <= cfg_data_i;
        mpa_pkg::REG_MOMENTUM_Y: mom_y_q <= cfg_data_i;
        mpa_pkg::REG_MOMENTUM_Z: mom_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // phase index: r = N mod D, k = round(r * PHASE_STEPS / D) mod PHASE_STEPS
  logic signed [CW:0]   dx, dy, dz;
  logic signed [PW-1:0] px, py, pz;
  logic [DW-1:0]        rx, ry, rz, r;
  logic [KW-1:0]        num;
  logic [PSL-1:0]       k_d;

  always_comb begin
    dx  = $signed({1'b0, site_x_i}) - $signed({1'b0, src_x_q});
    dy  = $signed({1'b0, site_y_i}) - $signed({1'b0, src_y_q});
    dz  = $signed({1'b0, site_z_i}) - $signed({1'b0, src_z_q});
    px  = PW'($signed(mom_x_q) * dx);
    py  = PW'($signed(mom_y_q) * dy);
    pz  = PW'($signed(mom_z_q) * dz);
    rx  = DW'(px[mpa_pkg::LAT_X_LOG2-1:0]) << SHX;
    ry  = DW'(py[mpa_pkg::LAT_Y_LOG2-1:0]) << SHY;
    rz  = DW'(pz[mpa_pkg::LAT_Z_LOG2-1:0]) << SHZ;
    r   = rx + ry + rz;
    num = (KW'(r) << (PSL + 1)) + (KW'(1) << DW);
    k_d = num[DW+1 +: PSL];
  end

  logic                                f_valid_q;
  logic [PSL-1:0]                      k_q;
  logic signed [mpa_pkg::VALUE_W-1:0]  vr_q, vi_q;
  logic                                last_q;
  logic                                f_adv;

  assign f_adv      = !f_valid_q || q_ready_i;
  assign in_stall_o = !f_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_adv) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv && in_valid_i) begin
      k_q    <= k_d;
      vr_q   <= value_re_i;
      vi_q   <= value_im_i;
      last_q <= last_site_i;
    end
  end

  // quarter-wave table and quadrant rotation
  logic [1:0]                    quad;
  logic [mpa_pkg::QUARTER_LOG2-1:0] j;
  logic [31:0]                   rom_word;
  logic signed [TW-1:0]          cc, ss;
  logic signed [TW-1:0]          c_v, s_v;

  always_comb begin
    quad     = k_q[PSL-1 -: 2];
    j        = k_q[mpa_pkg::QUARTER_LOG2-1:0];
    rom_word = mpa_pkg::TRIG_ROM[j];
    cc       = TW'($signed(rom_word[31:16]));
    ss       = TW'($signed(rom_word[15:0]));
    case (quad)
      2'd0: begin
        c_v = cc;
        s_v = ss;
      end
      2'd1: begin
        c_v = -ss;
        s_v = cc;
      end
      2'd2: begin
        c_v = -cc;
        s_v = -ss;
      end
      default: begin
        c_v = ss;
        s_v = -cc;
      end
    endcase
  end

  assign q_valid_o          = f_valid_q;
  assign q_item_o.cos_v     = c_v;
  assign q_item_o.sin_v     = s_v;
  assign q_item_o.value_re  = vr_q;
  assign q_item_o.value_im  = vi_q;
  assign q_item_o.last_site = last_q;

endmodule
`default_nettype wire

// ===== design/mpa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_queue
// Four-entry request queue between the phase front end and the
// multiply-accumulate back end.
// ----------------------------------------------------------------------------
module mpa_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_valid_i,
  output logic                    wr_ready_o,
  input  wire mpa_pkg::mpa_item_t wr_item_i,
  output logic                    rd_valid_o,
  input  wire logic               rd_pop_i,
  output mpa_pkg::mpa_item_t      rd_item_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  mpa_pkg::mpa_item_t mem_q [DEPTH];
  logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [AW:0]        count_q;
  logic               push, pop;

  assign wr_ready_o = count_q != (AW+1)'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
      if (push && !pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mpa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_back
// Complex multiply, rounding and saturating accumulation; holds the
// result register for the output channel.
// ----------------------------------------------------------------------------
module mpa_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  output logic                                    q_pop_o,
  input  wire mpa_pkg::mpa_item_t                 q_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [mpa_pkg::ACC_W-1:0]        sum_re_o,
  output logic signed [mpa_pkg::ACC_W-1:0]        sum_im_o,
  output logic                                    saturated_o
);

  localparam int unsigned MW = mpa_pkg::VALUE_W + mpa_pkg::TRIG_W;
  localparam int unsigned SW = MW + 2;
  localparam int unsigned TW = SW - 15;
  localparam int unsigned AW = mpa_pkg::ACC_W;

  // multiply stage
  logic                 m_valid_q;
  logic signed [MW-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic                 m_last_q;
  logic                 a_ok, m_adv, a_fire;

  assign a_ok    = !m_last_q || !out_valid_o || !out_stall_i;
  assign m_adv   = !m_valid_q || a_ok;
  assign q_pop_o = q_valid_i && m_adv;
  assign a_fire  = m_valid_q && a_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_adv) begin
      m_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      p_rc_q   <= q_item_i.value_re * q_item_i.cos_v;
      p_is_q   <= q_item_i.value_im * q_item_i.sin_v;
      p_ic_q   <= q_item_i.value_im * q_item_i.cos_v;
      p_rs_q   <= q_item_i.value_re * q_item_i.sin_v;
      m_last_q <= q_item_i.last_site;
    end
  end

  // round, saturate, accumulate
  function automatic logic [AW:0] sat_add(input logic signed [AW-1:0] a,
                                          input logic signed [TW-1:0] b);
    logic signed [AW:0] t;
    t = (AW+1)'(a) + (AW+1)'(b);
    if (t[AW] != t[AW-1]) begin
      return {1'b1, t[AW], {(AW-1){~t[AW]}}};
    end
    return {1'b0, t[AW-1:0]};
  endfunction

  logic signed [SW-1:0] s_re, s_im;
  logic signed [TW-1:0] t_re, t_im;
  logic [AW:0]          n_re, n_im;
  logic signed [AW-1:0] acc_re_q, acc_im_q;
  logic                 ovf_q;
  logic                 ovf_now;

  always_comb begin
    s_re    = SW'(p_rc_q) + SW'(p_is_q) + SW'(16384);
    s_im    = SW'(p_ic_q) - SW'(p_rs_q) + SW'(16384);
    t_re    = s_re[SW-1:15];
    t_im    = s_im[SW-1:15];
    n_re    = sat_add(acc_re_q, t_re);
    n_im    = sat_add(acc_im_q, t_im);
    ovf_now = n_re[AW] || n_im[AW];
  end

  logic                 out_valid_q;
  logic signed [AW-1:0] out_re_q, out_im_q;
  logic                 out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_fire) begin
        if (m_last_q) begin
          acc_re_q <= '0;
          acc_im_q <= '0;
          ovf_q    <= 1'b0;
        end else begin
          acc_re_q <= n_re[AW-1:0];
          acc_im_q <= n_im[AW-1:0];
          ovf_q    <= ovf_q || ovf_now;
        end
      end
      if (a_fire && m_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && m_last_q) begin
      out_re_q  <= n_re[AW-1:0];
      out_im_q  <= n_im[AW-1:0];
      out_sat_q <= ovf_q || ovf_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_re_o    = out_re_q;
  assign sum_im_o    = out_im_q;
  assign saturated_o = out_sat_q;

endmodule
`default_nettype wire

// ===== design/momentum_projection_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// momentum_projection_accumulator
// Streams lattice sites and accumulates value * exp(-i p.d) per sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one site request per
//   cycle while in_stall_o is low: coordinate, complex value, last_site.
//   Output channel (out_valid_o / out_stall_i) returns one saturated complex
//   sum, plus a saturation flag, for each request with last_site set.
//   Config channel (cfg_valid_i / cfg_ready_o) writes source and momentum
//   registers by index; always ready. The user must write them only while
//   the block is idle; the block does not enforce it. Throughput: one site
//   per cycle while in_stall_o is low. out_valid_o rises once a last site has
//   passed the front, queue, multiplier and accumulator/result registers.
//   When the receiver stalls, the result register holds; non-final sites
//   keep accumulating and the four-entry queue absorbs the front end until
//   the back end blocks on a second final site.
//   Reset clears registers, accumulators and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module momentum_projection_accumulator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mpa_pkg::IDX_W-1:0]          cfg_index_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [mpa_pkg::COORD_W-1:0]        site_x_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]        site_y_i,
  input  wire logic [mpa_pkg::COORD_W-1:0]        site_z_i,
  input  wire logic signed [mpa_pkg::VALUE_W-1:0] value_re_i,
  input  wire logic signed [mpa_pkg::VALUE_W-1:0] value_im_i,
  input  wire logic                               last_site_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [mpa_pkg::ACC_W-1:0]        sum_re_o,
  output logic signed [mpa_pkg::ACC_W-1:0]        sum_im_o,
  output logic                                    saturated_o
);

  logic               fq_valid, fq_ready;
  mpa_pkg::mpa_item_t fq_item;
  logic               qb_valid, qb_pop;
  mpa_pkg::mpa_item_t qb_item;

  assign cfg_ready_o = 1'b1;

  mpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .site_x_i    (site_x_i),
    .site_y_i    (site_y_i),
    .site_z_i    (site_z_i),
    .value_re_i  (value_re_i),
    .value_im_i  (value_im_i),
    .last_site_i (last_site_i),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_item_o    (fq_item)
  );

  mpa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_pop_i   (qb_pop),
    .rd_item_o  (qb_item)
  );

  mpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_pop_o     (qb_pop),
    .q_item_i    (qb_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_re_o    (sum_re_o),
    .sum_im_o    (sum_im_o),
    .saturated_o (saturated_o)
  );

endmodule
`default_nettype wire
